>>> hw/rtl/i3ag_pkg.sv
package i3ag_pkg;

  localparam int COL_W     = 24;
  localparam int GRID_W    = 9;
  localparam int PLANE_W   = 2 * GRID_W;
  localparam int SIDE_W    = 9;
  localparam int MAX_SIDE  = 256;
  localparam int MAX_KERNEL = 4;
  localparam int K_W       = 2;
  localparam int TAP_W     = 6;
  localparam int ADDR_W    = 24;
  localparam int CFG_W     = 9;
  localparam int IDX_W     = 3;
  // Signed window and tap coordinates: up to (2^24 - 1) * 15 + 189, down to -127.
  localparam int COORD_W   = 30;

  localparam logic [IDX_W-1:0] REG_KERNEL_SIZE = 3'd0;
  localparam logic [IDX_W-1:0] REG_STRIDE      = 3'd1;
  localparam logic [IDX_W-1:0] REG_PAD         = 3'd2;
  localparam logic [IDX_W-1:0] REG_DILATION    = 3'd3;
  localparam logic [IDX_W-1:0] REG_VOL_SIDE    = 3'd4;
  localparam logic [IDX_W-1:0] REG_GRID_X      = 3'd5;
  localparam logic [IDX_W-1:0] REG_GRID_Y      = 3'd6;

  // Configuration after clamping, as the datapath uses it.
  typedef struct packed {
    logic [K_W-1:0]     k_m1;
    logic [TAP_W-1:0]   total_m1;
    logic [3:0]         stride;
    logic [6:0]         pad;
    logic [5:0]         dil;
    logic [SIDE_W-1:0]  side;
    logic [GRID_W-1:0]  gx;
    logic [PLANE_W-1:0] plane;
  } cfg_t;

  // Start corner of one window in source coordinates.
  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] sz;
  } win_t;

endpackage

>>> hw/rtl/i3ag_window.sv
module i3ag_window (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [i3ag_pkg::COL_W-1:0] in_col,
  input  i3ag_pkg::cfg_t      cfg,
  output logic                out_vld,
  output i3ag_pkg::win_t      out_win
);

  localparam int DIV1_LAST = i3ag_pkg::COL_W;
  localparam int DIV_LAST  = i3ag_pkg::COL_W + i3ag_pkg::PLANE_W;

  typedef struct packed {
    logic [i3ag_pkg::COL_W-1:0]   col;
    logic [i3ag_pkg::COL_W-1:0]   wz;
    logic [i3ag_pkg::PLANE_W-1:0] r1;
    logic [i3ag_pkg::GRID_W-1:0]  wy;
    logic [i3ag_pkg::GRID_W-1:0]  r2;
  } stage_t;

  logic   vld_r [0:DIV_LAST];
  stage_t stg_r [0:DIV_LAST];
  stage_t stg_nxt [1:DIV_LAST];

  logic           win_vld_r;
  i3ag_pkg::win_t win_r;
  i3ag_pkg::win_t win_nxt;

  logic [12:0] px;
  logic [12:0] py;
  logic [27:0] pz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0].col <= in_col;
      stg_r[0].wz  <= '0;
      stg_r[0].r1  <= '0;
      stg_r[0].wy  <= '0;
      stg_r[0].r2  <= '0;
    end
  end

  // One quotient bit per stage: first the window index by the plane size,
  // then the remainder by the grid width.
  for (genvar j = 1; j <= DIV_LAST; j++) begin : g_div
    if (j <= DIV1_LAST) begin : g_plane
      logic [i3ag_pkg::PLANE_W:0] tmp;
      logic                       ge;
      always_comb begin
        tmp = {stg_r[j-1].r1, stg_r[j-1].col[i3ag_pkg::COL_W-j]};
        ge  = tmp >= {1'b0, cfg.plane};
        stg_nxt[j]    = stg_r[j-1];
        stg_nxt[j].r1 = ge ? i3ag_pkg::PLANE_W'(tmp - {1'b0, cfg.plane})
                           : tmp[i3ag_pkg::PLANE_W-1:0];
        stg_nxt[j].wz = {stg_r[j-1].wz[i3ag_pkg::COL_W-2:0], ge};
      end
    end else begin : g_row
      logic [i3ag_pkg::GRID_W:0] tmp;
      logic                      ge;
      always_comb begin
        tmp = {stg_r[j-1].r2, stg_r[j-1].r1[DIV_LAST-j]};
        ge  = tmp >= {1'b0, cfg.gx};
        stg_nxt[j]    = stg_r[j-1];
        stg_nxt[j].r2 = ge ? i3ag_pkg::GRID_W'(tmp - {1'b0, cfg.gx})
                           : tmp[i3ag_pkg::GRID_W-1:0];
        stg_nxt[j].wy = {stg_r[j-1].wy[i3ag_pkg::GRID_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[j] <= stg_nxt[j];
      end
    end
  end

  always_comb begin
    px = {4'b0, stg_r[DIV_LAST].r2} * {9'b0, cfg.stride};
    py = {4'b0, stg_r[DIV_LAST].wy} * {9'b0, cfg.stride};
    pz = {4'b0, stg_r[DIV_LAST].wz} * {24'b0, cfg.stride};
    win_nxt.sx = $signed(i3ag_pkg::COORD_W'(px)) - $signed(i3ag_pkg::COORD_W'(cfg.pad));
    win_nxt.sy = $signed(i3ag_pkg::COORD_W'(py)) - $signed(i3ag_pkg::COORD_W'(cfg.pad));
    win_nxt.sz = $signed(i3ag_pkg::COORD_W'(pz)) - $signed(i3ag_pkg::COORD_W'(cfg.pad));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_vld_r <= 1'b0;
    end else if (en) begin
      win_vld_r <= vld_r[DIV_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      win_r <= win_nxt;
    end
  end

  assign out_vld = win_vld_r;
  assign out_win = win_r;

endmodule

>>> hw/rtl/im2col_3d_address_generator.sv
// 3D im2col address generator.
// Input channel (in_*): one output window position per transfer, x fastest,
// then y, then z over a grid_x by grid_y grid. For every kernel tap, in z, y,
// x order, the result channel (out_*) gives the tap number, the linear source
// voxel address, an inside flag (zero padding when low, address then zero)
// and a last flag on the final tap of the window.
// Configuration (cfg_*): write enable, register index and data; the user
// must write registers only while the block is empty, and the block itself
// leaves this unchecked. Unknown indexes are ignored. A window passes an
// input register, a 42-stage one-bit-per-stage divider that splits the
// window position, one stage that forms the window start and the tap
// sequencer; four stages then turn each tap into an address.
// Throughput: one tap per cycle while the result channel does not stall;
// a window has kernel_size^3 taps (27 for 3x3x3), in_stall stays high while
// the sequencer walks it; a 1x1x1 kernel takes a window every such cycle.
// Reset (rst_n, synchronous) empties the pipeline and loads the register
// defaults. A stall on the result channel freezes the whole pipeline, and
// the input channel stalls with it; nothing is lost or repeated.
module im2col_3d_address_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [i3ag_pkg::COL_W-1:0]        in_column_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [i3ag_pkg::TAP_W-1:0]        out_tap_index,
  output logic [i3ag_pkg::ADDR_W-1:0]       out_source_addr,
  output logic                              out_inside_res,
  output logic                              out_last_tap,
  input  logic                              cfg_we,
  input  logic [i3ag_pkg::IDX_W-1:0]        cfg_index,
  input  logic [i3ag_pkg::CFG_W-1:0]        cfg_wdata
);

  // Configuration registers.
  logic [2:0]                  kernel_r;
  logic [3:0]                  stride_r;
  logic [6:0]                  pad_r;
  logic [5:0]                  dil_r;
  logic [i3ag_pkg::SIDE_W-1:0] side_r;
  logic [i3ag_pkg::GRID_W-1:0] grid_x_r;
  logic [i3ag_pkg::GRID_W-1:0] grid_y_r;

  i3ag_pkg::cfg_t              cfg_d_r;
  i3ag_pkg::cfg_t              cfg_d_nxt;
  logic [i3ag_pkg::GRID_W-1:0] gy_eff;

  logic           adv;
  logic           gen_take;
  logic           gen_last;
  logic           win_en;
  logic           win_vld;
  i3ag_pkg::win_t win;

  // Tap sequencer.
  logic                       gen_vld_r, gen_vld_nxt;
  i3ag_pkg::win_t             gen_win_r, gen_win_nxt;
  logic [i3ag_pkg::K_W-1:0]   gen_tx_r, gen_tx_nxt;
  logic [i3ag_pkg::K_W-1:0]   gen_ty_r, gen_ty_nxt;
  logic [i3ag_pkg::K_W-1:0]   gen_tz_r, gen_tz_nxt;
  logic [i3ag_pkg::TAP_W-1:0] gen_tap_r, gen_tap_nxt;

  // Tap coordinates.
  logic                              a_vld_r;
  logic signed [i3ag_pkg::COORD_W-1:0] a_cx_r, a_cy_r, a_cz_r;
  logic [i3ag_pkg::TAP_W-1:0]        a_tap_r;
  logic                              a_last_r;
  logic [7:0]                        ox, oy, oz;

  // Inside test and plane product.
  logic                       b_vld_r;
  logic                       b_inside_r;
  logic [16:0]                b_prod_r;
  logic [7:0]                 b_cy_r, b_cx_r;
  logic [i3ag_pkg::TAP_W-1:0] b_tap_r;
  logic                       b_last_r;
  logic                       in_x, in_y, in_z;

  // Row product.
  logic                        c_vld_r;
  logic                        c_inside_r;
  logic [i3ag_pkg::ADDR_W-1:0] c_prod_r;
  logic [7:0]                  c_cx_r;
  logic [i3ag_pkg::TAP_W-1:0]  c_tap_r;
  logic                        c_last_r;
  logic [16:0]                 row_sum;
  logic [25:0]                 row_prod;

  // Output register.
  logic                        out_vld_r;
  logic [i3ag_pkg::TAP_W-1:0]  out_tap_r;
  logic [i3ag_pkg::ADDR_W-1:0] out_addr_r;
  logic                        out_inside_r;
  logic                        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r <= 3'd3;
      stride_r <= 4'd1;
      pad_r    <= 7'd1;
      dil_r    <= 6'd1;
      side_r   <= 9'd256;
      grid_x_r <= 9'd256;
      grid_y_r <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i3ag_pkg::REG_KERNEL_SIZE: kernel_r <= cfg_wdata[2:0];
        i3ag_pkg::REG_STRIDE:      stride_r <= cfg_wdata[3:0];
        i3ag_pkg::REG_PAD:         pad_r    <= cfg_wdata[6:0];
        i3ag_pkg::REG_DILATION:    dil_r    <= cfg_wdata[5:0];
        i3ag_pkg::REG_VOL_SIDE:    side_r   <= cfg_wdata;
        i3ag_pkg::REG_GRID_X:      grid_x_r <= cfg_wdata;
        i3ag_pkg::REG_GRID_Y:      grid_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamped configuration, registered once; it is settled well before any
  // item reaches the stages that use it.
  always_comb begin
    priority if (kernel_r == 3'd0) begin
      cfg_d_nxt.k_m1 = 2'd0;
    end else if (kernel_r > 3'(i3ag_pkg::MAX_KERNEL)) begin
      cfg_d_nxt.k_m1 = 2'(i3ag_pkg::MAX_KERNEL - 1);
    end else begin
      cfg_d_nxt.k_m1 = 2'(kernel_r - 3'd1);
    end
    unique case (cfg_d_nxt.k_m1)
      2'd0: cfg_d_nxt.total_m1 = 6'd0;
      2'd1: cfg_d_nxt.total_m1 = 6'd7;
      2'd2: cfg_d_nxt.total_m1 = 6'd26;
      2'd3: cfg_d_nxt.total_m1 = 6'd63;
      default: cfg_d_nxt.total_m1 = 6'd0;
    endcase
    cfg_d_nxt.stride = stride_r;
    cfg_d_nxt.pad    = pad_r;
    cfg_d_nxt.dil    = dil_r;
    cfg_d_nxt.side   = (side_r > 9'(i3ag_pkg::MAX_SIDE)) ? 9'(i3ag_pkg::MAX_SIDE) : side_r;
    cfg_d_nxt.gx     = (grid_x_r == '0) ? 9'd1 : grid_x_r;
    gy_eff           = (grid_y_r == '0) ? 9'd1 : grid_y_r;
    cfg_d_nxt.plane  = {9'b0, cfg_d_nxt.gx} * {9'b0, gy_eff};
  end

  always_ff @(posedge clk) begin
    cfg_d_r <= cfg_d_nxt;
  end

  assign adv      = !out_vld_r || !out_stall;
  assign gen_last = (gen_tx_r == cfg_d_r.k_m1) && (gen_ty_r == cfg_d_r.k_m1) &&
                    (gen_tz_r == cfg_d_r.k_m1);
  assign gen_take = !gen_vld_r || gen_last;
  assign win_en   = adv && gen_take;
  assign in_stall = !win_en;

  i3ag_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (win_en),
    .in_vld  (in_valid),
    .in_col  (in_column_index),
    .cfg     (cfg_d_r),
    .out_vld (win_vld),
    .out_win (win)
  );

  always_comb begin
    gen_vld_nxt = gen_vld_r;
    gen_win_nxt = gen_win_r;
    gen_tx_nxt  = gen_tx_r;
    gen_ty_nxt  = gen_ty_r;
    gen_tz_nxt  = gen_tz_r;
    gen_tap_nxt = gen_tap_r;
    if (gen_take) begin
      gen_vld_nxt = win_vld;
      gen_win_nxt = win;
      gen_tx_nxt  = '0;
      gen_ty_nxt  = '0;
      gen_tz_nxt  = '0;
      gen_tap_nxt = '0;
    end else begin
      gen_tap_nxt = gen_tap_r + 6'd1;
      if (gen_tx_r == cfg_d_r.k_m1) begin
        gen_tx_nxt = '0;
        if (gen_ty_r == cfg_d_r.k_m1) begin
          gen_ty_nxt = '0;
          gen_tz_nxt = gen_tz_r + 2'd1;
        end else begin
          gen_ty_nxt = gen_ty_r + 2'd1;
        end
      end else begin
        gen_tx_nxt = gen_tx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_vld_r <= 1'b0;
    end else if (adv) begin
      gen_vld_r <= gen_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gen_win_r <= gen_win_nxt;
      gen_tx_r  <= gen_tx_nxt;
      gen_ty_r  <= gen_ty_nxt;
      gen_tz_r  <= gen_tz_nxt;
      gen_tap_r <= gen_tap_nxt;
    end
  end

  always_comb begin
    ox = {6'b0, gen_tx_r} * {2'b0, cfg_d_r.dil};
    oy = {6'b0, gen_ty_r} * {2'b0, cfg_d_r.dil};
    oz = {6'b0, gen_tz_r} * {2'b0, cfg_d_r.dil};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r   <= gen_vld_r;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      out_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cx_r   <= gen_win_r.sx + $signed(i3ag_pkg::COORD_W'(ox));
      a_cy_r   <= gen_win_r.sy + $signed(i3ag_pkg::COORD_W'(oy));
      a_cz_r   <= gen_win_r.sz + $signed(i3ag_pkg::COORD_W'(oz));
      a_tap_r  <= gen_tap_r;
      a_last_r <= gen_vld_r && gen_last;
    end
  end

  // Coordinates are known non-negative once the sign bit is clear, so the
  // upper bound is an unsigned compare.
  always_comb begin
    in_x = !a_cx_r[i3ag_pkg::COORD_W-1] &&
           (a_cx_r[i3ag_pkg::COORD_W-2:0] < (i3ag_pkg::COORD_W-1)'(cfg_d_r.side));
    in_y = !a_cy_r[i3ag_pkg::COORD_W-1] &&
           (a_cy_r[i3ag_pkg::COORD_W-2:0] < (i3ag_pkg::COORD_W-1)'(cfg_d_r.side));
    in_z = !a_cz_r[i3ag_pkg::COORD_W-1] &&
           (a_cz_r[i3ag_pkg::COORD_W-2:0] < (i3ag_pkg::COORD_W-1)'(cfg_d_r.side));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_inside_r <= in_x && in_y && in_z;
      b_prod_r   <= {9'b0, a_cz_r[7:0]} * {8'b0, cfg_d_r.side};
      b_cy_r     <= a_cy_r[7:0];
      b_cx_r     <= a_cx_r[7:0];
      b_tap_r    <= a_tap_r;
      b_last_r   <= a_last_r;
    end
  end

  always_comb begin
    row_sum  = b_prod_r + {9'b0, b_cy_r};
    row_prod = {9'b0, row_sum} * {17'b0, cfg_d_r.side};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_inside_r <= b_inside_r;
      c_prod_r   <= row_prod[i3ag_pkg::ADDR_W-1:0];
      c_cx_r     <= b_cx_r;
      c_tap_r    <= b_tap_r;
      c_last_r   <= b_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_inside_r <= c_inside_r;
      out_addr_r   <= c_inside_r ? c_prod_r + {16'b0, c_cx_r} : '0;
      out_tap_r    <= c_tap_r;
      out_last_r   <= c_last_r;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_tap_index   = out_tap_r;
  assign out_source_addr = out_addr_r;
  assign out_inside_res  = out_inside_r;
  assign out_last_tap    = out_last_r;

`ifndef ASSERT_OFF
  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_last_r |-> out_tap_r == cfg_d_r.total_m1)
    else $error("last tap does not close a full window");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_inside_r |-> out_addr_r == '0)
    else $error("padding tap carries a nonzero address");

  a_tap_step: assert property (@(posedge clk) disable iff (!rst_n)
    gen_vld_r && !gen_last && adv |=> gen_tap_r == $past(gen_tap_r) + 6'd1)
    else $error("tap sequencer skipped or repeated a tap");

  a_gen_drain: assert property (@(posedge clk) disable iff (!rst_n)
    gen_vld_r && gen_last && adv && !win_vld |=> !gen_vld_r)
    else $error("tap sequencer kept running after its window ended");
`endif

endmodule

>>> dv/im2col_tap_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the address generator, keeps its own copy of the
// configuration registers and predicts the tap sequence of every window.
module im2col_tap_checker
  import i3ag_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [COL_W-1:0]  in_column_index,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [TAP_W-1:0]  out_tap_index,
  input  logic [ADDR_W-1:0] out_source_addr,
  input  logic              out_inside_res,
  input  logic              out_last_tap,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output int                taps_outstanding,
  output int                mismatch_count
);

  typedef struct packed {
    logic [TAP_W-1:0]  tap;
    logic [ADDR_W-1:0] addr;
    logic              in_vol;
    logic              last;
  } window_tap_t;

  window_tap_t expected_taps[$];

  logic [2:0]        kernel_r;
  logic [3:0]        stride_r;
  logic [6:0]        pad_r;
  logic [5:0]        dil_r;
  logic [SIDE_W-1:0] side_r;
  logic [GRID_W-1:0] gx_r;
  logic [GRID_W-1:0] gy_r;

  initial begin
    taps_outstanding = 0;
    mismatch_count = 0;
  end

  // Splits the window position and walks the kernel in z, y, x order.
  task automatic queue_window_taps(input logic [COL_W-1:0] col);
    longint k, gx, gy, side, plane, wx, wy, wz, rem, total, n;
    longint stride_v, pad_v, dil_v, sx, sy, sz, cx, cy, cz;
    longint z, y, x;
    window_tap_t t;
    k = kernel_r;
    if (k == 0) k = 1;
    if (k > MAX_KERNEL) k = MAX_KERNEL;
    gx = (gx_r == 0) ? 1 : gx_r;
    gy = (gy_r == 0) ? 1 : gy_r;
    side = (side_r > MAX_SIDE) ? MAX_SIDE : side_r;
    stride_v = stride_r;
    pad_v = pad_r;
    dil_v = dil_r;
    plane = gx * gy;
    wz = col / plane;
    rem = col % plane;
    wy = rem / gx;
    wx = rem % gx;
    sx = wx * stride_v - pad_v;
    sy = wy * stride_v - pad_v;
    sz = wz * stride_v - pad_v;
    total = k * k * k;
    n = 0;
    for (z = 0; z < k; z++) begin
      cz = sz + z * dil_v;
      for (y = 0; y < k; y++) begin
        cy = sy + y * dil_v;
        for (x = 0; x < k; x++) begin
          cx = sx + x * dil_v;
          t.in_vol = (cx >= 0 && cx < side && cy >= 0 && cy < side &&
                      cz >= 0 && cz < side);
          t.addr = t.in_vol ? ADDR_W'((cz * side + cy) * side + cx) : '0;
          t.tap = TAP_W'(z * k * k + y * k + x);
          n++;
          t.last = (n == total);
          expected_taps.push_back(t);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    window_tap_t exp_tap;
    if (!rst_n) begin
      kernel_r <= 3'd3;
      stride_r <= 4'd1;
      pad_r <= 7'd1;
      dil_r <= 6'd1;
      side_r <= SIDE_W'(256);
      gx_r <= GRID_W'(256);
      gy_r <= GRID_W'(256);
      expected_taps.delete();
      taps_outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KERNEL_SIZE: kernel_r <= cfg_wdata[2:0];
          REG_STRIDE:      stride_r <= cfg_wdata[3:0];
          REG_PAD:         pad_r <= cfg_wdata[6:0];
          REG_DILATION:    dil_r <= cfg_wdata[5:0];
          REG_VOL_SIDE:    side_r <= cfg_wdata[SIDE_W-1:0];
          REG_GRID_X:      gx_r <= cfg_wdata[GRID_W-1:0];
          REG_GRID_Y:      gy_r <= cfg_wdata[GRID_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) queue_window_taps(in_column_index);
      if (out_valid && !out_stall) begin
        if (expected_taps.size() == 0) begin
          $error("unexpected tap transfer: tap_index %0d source_addr %0h",
                 out_tap_index, out_source_addr);
          mismatch_count++;
        end else begin
          exp_tap = expected_taps.pop_front();
          if (out_tap_index !== exp_tap.tap) begin
            $error("tap_index: expected %0d, actual %0d", exp_tap.tap, out_tap_index);
            mismatch_count++;
          end
          if (out_source_addr !== exp_tap.addr) begin
            $error("source_addr: expected %0h, actual %0h", exp_tap.addr,
                   out_source_addr);
            mismatch_count++;
          end
          if (out_inside_res !== exp_tap.in_vol) begin
            $error("inside_res: expected %0b, actual %0b", exp_tap.in_vol,
                   out_inside_res);
            mismatch_count++;
          end
          if (out_last_tap !== exp_tap.last) begin
            $error("last_tap: expected %0b, actual %0b", exp_tap.last, out_last_tap);
            mismatch_count++;
          end
        end
      end
      taps_outstanding <= expected_taps.size();
    end
  end

endmodule

>>> dv/im2col_3d_address_generator_tb.sv
`timescale 1ns / 1ps

module im2col_3d_address_generator_tb;
  import i3ag_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int CONFIGS_PER_PHASE = 4;
  localparam int WINDOWS_PER_CONFIG = 20;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [COL_W-1:0]  in_column_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [TAP_W-1:0]  out_tap_index;
  logic [ADDR_W-1:0] out_source_addr;
  logic              out_inside_res;
  logic              out_last_tap;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  int taps_outstanding;
  int mismatch_count;
  int cycle_count = 0;
  int tx_gap_pct = 11;
  int rx_stall_pct = 66;

  // Grid and volume as last written, used to aim window positions.
  int unsigned grid_x_now = 256;
  int unsigned grid_y_now = 256;
  int unsigned side_now = 256;

  im2col_3d_address_generator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_column_index (in_column_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tap_index   (out_tap_index),
    .out_source_addr (out_source_addr),
    .out_inside_res  (out_inside_res),
    .out_last_tap    (out_last_tap),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  im2col_tap_checker i_tap_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_column_index  (in_column_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tap_index    (out_tap_index),
    .out_source_addr  (out_source_addr),
    .out_inside_res   (out_inside_res),
    .out_last_tap     (out_last_tap),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .taps_outstanding (taps_outstanding),
    .mismatch_count   (mismatch_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Leaves cfg_we high; the caller lowers it after the last write.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(data);
    case (idx)
      REG_VOL_SIDE: side_now = data;
      REG_GRID_X:   grid_x_now = data;
      REG_GRID_Y:   grid_y_now = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_config(input int unsigned k, input int unsigned stride,
                             input int unsigned pad, input int unsigned dil,
                             input int unsigned side, input int unsigned gx,
                             input int unsigned gy);
    write_reg(REG_KERNEL_SIZE, k);
    write_reg(REG_STRIDE, stride);
    write_reg(REG_PAD, pad);
    write_reg(REG_DILATION, dil);
    write_reg(REG_VOL_SIDE, side);
    write_reg(REG_GRID_X, gx);
    write_reg(REG_GRID_Y, gy);
    cfg_we <= 1'b0;
  endtask

  task automatic send_column(input logic [COL_W-1:0] col);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_column_index <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds the input back until every predicted tap has been seen.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (taps_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly windows inside the configured grid, with some z depth past the
  // volume, and now and then any 24-bit position.
  function automatic logic [COL_W-1:0] pick_column();
    int unsigned gx, gy, col;
    int unsigned z_hi;
    gx = (grid_x_now == 0) ? 1 : grid_x_now;
    gy = (grid_y_now == 0) ? 1 : grid_y_now;
    z_hi = (side_now > 300) ? 300 : side_now + 2;
    if ($urandom_range(0, 99) < 25) return COL_W'($urandom());
    col = $urandom_range(0, gx - 1) +
          gx * ($urandom_range(0, gy - 1) + gy * $urandom_range(0, z_hi));
    return COL_W'(col);
  endfunction

  task automatic load_random_config(input bit wild);
    int unsigned side;
    if (wild) begin
      load_config($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 127),
                  $urandom_range(0, 63), $urandom_range(0, 511),
                  $urandom_range(0, 511), $urandom_range(0, 511));
    end else begin
      // Small volumes with small offsets keep taps straddling the border.
      side = $urandom_range(1, 40);
      load_config($urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(0, 3),
                  $urandom_range(1, 3), side, $urandom_range(1, side),
                  $urandom_range(1, side));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults straight out of reset, extremes of the window position.
    send_column('0);
    send_column('1);
    send_column(COL_W'(257));
    send_column(COL_W'(65535));
    wait_drained();

    // Single tap, zero stride and dilation, zero grid, one-voxel volume;
    // the write to the unused index must leave everything alone.
    write_reg(REG_UNUSED, 511);
    load_config(1, 0, 0, 0, 1, 0, 0);
    send_column('0);
    send_column(COL_W'(5));
    wait_drained();

    // Kernel and volume above their maxima, every field at its top value.
    load_config(7, 15, 127, 63, 511, 511, 511);
    send_column('0);
    send_column('1);
    send_column(COL_W'(24'h5A5A5A));
    wait_drained();

    // Zero kernel size and an empty volume: every tap is padding.
    load_config(0, 8, 64, 32, 0, 256, 1);
    send_column(COL_W'(3));
    send_column(COL_W'(1000));
    wait_drained();

    // A full 4x4x4 kernel over a 4-voxel cube, then edges with padding.
    load_config(4, 1, 0, 1, 4, 1, 1);
    send_column('0);
    send_column(COL_W'(1));
    wait_drained();
    load_config(2, 2, 1, 2, 5, 3, 3);
    send_column('0);
    send_column(COL_W'(4));
    send_column(COL_W'(8));
    send_column(COL_W'(26));
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_gap_pct = 11;
          rx_stall_pct = 66;
        end
        1: begin
          tx_gap_pct = 66;
          rx_stall_pct = 11;
        end
        default: begin
          tx_gap_pct = 0;
          rx_stall_pct = 0;
        end
      endcase
      for (int cfg_set = 0; cfg_set < CONFIGS_PER_PHASE; cfg_set++) begin
        load_random_config(cfg_set == CONFIGS_PER_PHASE - 1);
        for (int i = 0; i < WINDOWS_PER_CONFIG; i++) send_column(pick_column());
        wait_drained();
      end
    end

    if (mismatch_count == 0 && taps_outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
